[hdl/flfr_pkg.sv]
// Shared types, constants and a helper function of the fixed-length frame receiver.
`timescale 1ns / 1ps

package flfr_pkg;

  // Number of bytes in the preamble and in the trailer.
  localparam int MARK_LEN = 5;

  // Default payload store depth.
  localparam int PAYLOAD_MAX_DEF = 32;

  // Field widths of the channels.
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 5;
  localparam int LENGTH_W  = 6;
  localparam int WORD_W    = 40;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_WORD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_WORD   = 2'd2;

  // Reset values of the configuration registers ("$00RF" and "<EOM>").
  localparam logic [LENGTH_W-1:0] PAYLOAD_LENGTH_RST = 6'd32;
  localparam logic [WORD_W-1:0]   PREAMBLE_WORD_RST  = 40'h2430305246;
  localparam logic [WORD_W-1:0]   TRAILER_WORD_RST   = 40'h3C454F4D3E;

  typedef struct packed {
    logic [LENGTH_W-1:0] payload_length;
    logic [WORD_W-1:0]   preamble_word;
    logic [WORD_W-1:0]   trailer_word;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_LOAD,
    S_SEND
  } state_t;

  // Picks byte idx of a marker word; byte 0 is the most significant one.
  function automatic logic [BYTE_W-1:0] mark_byte(input logic [WORD_W-1:0] word,
                                                  input logic [2:0] idx);
    logic [BYTE_W-1:0] sel;
    case (idx)
      3'd0:    sel = word[39:32];
      3'd1:    sel = word[31:24];
      3'd2:    sel = word[23:16];
      3'd3:    sel = word[15:8];
      3'd4:    sel = word[7:0];
      default: sel = '0;
    endcase
    return sel;
  endfunction

endpackage

[hdl/flfr_intf.sv]
// Handshake channel interfaces of the fixed-length frame receiver.
`timescale 1ns / 1ps

interface flfr_in_if;
  logic                           valid;
  logic                           ready;
  logic [flfr_pkg::BYTE_W-1:0]    rx_byte;
  logic                           rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface flfr_out_if;
  logic                           valid;
  logic                           ready;
  logic [flfr_pkg::BYTE_W-1:0]    payload_byte;
  logic [flfr_pkg::INDEX_W-1:0]   payload_index;
  logic                           last;

  modport source (output valid, output payload_byte, output payload_index, output last,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_index, input last,
                  output ready);
endinterface

interface flfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [flfr_pkg::CFG_IDX_W-1:0] index;
  logic [flfr_pkg::WORD_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hdl/flfr_cfg_regs.sv]
// Configuration register file of the fixed-length frame receiver.
`timescale 1ns / 1ps

module flfr_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  flfr_cfg_if.sink            cfg_if,
  output flfr_pkg::cfg_regs_t cfg
);

  flfr_pkg::cfg_regs_t cfg_r;
  flfr_pkg::cfg_regs_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        flfr_pkg::REG_PAYLOAD_LENGTH: cfg_nxt.payload_length =
                                        cfg_if.wdata[flfr_pkg::LENGTH_W-1:0];
        flfr_pkg::REG_PREAMBLE_WORD:  cfg_nxt.preamble_word = cfg_if.wdata;
        flfr_pkg::REG_TRAILER_WORD:   cfg_nxt.trailer_word  = cfg_if.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_length <= flfr_pkg::PAYLOAD_LENGTH_RST;
      cfg_r.preamble_word  <= flfr_pkg::PREAMBLE_WORD_RST;
      cfg_r.trailer_word   <= flfr_pkg::TRAILER_WORD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/flfr_store.sv]
// Payload byte memory: one write port, one registered read port.
`timescale 1ns / 1ps

module flfr_store #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [flfr_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [flfr_pkg::BYTE_W-1:0] rd_data
);

  logic [flfr_pkg::BYTE_W-1:0] mem [PAYLOAD_MAX];
  logic [flfr_pkg::BYTE_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[hdl/flfr_ctrl.sv]
// Frame sequencer: position tracking, shared byte comparator and payload drain.
`timescale 1ns / 1ps

module flfr_ctrl #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  flfr_pkg::cfg_regs_t         cfg,
  flfr_in_if.sink                     in_if,
  flfr_out_if.source                  out_if,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [flfr_pkg::BYTE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [flfr_pkg::BYTE_W-1:0] rd_data
);

  localparam int POS_W = $clog2(2 * flfr_pkg::MARK_LEN + PAYLOAD_MAX + 1);
  localparam int WW    = (POS_W + 1 > 7) ? POS_W + 1 : 7;

  flfr_pkg::state_t state_r, state_nxt;

  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [flfr_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic [AW-1:0]                k_r, k_nxt;
  logic [flfr_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [flfr_pkg::INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic                         last_r, last_nxt;

  logic [WW-1:0] pl_w, len_w, pos_w, pos_inc, pay_end, trl_end, mark_w;
  logic          in_pre, in_pay, in_trl;
  logic [2:0]    mark_idx;
  logic [flfr_pkg::BYTE_W-1:0] expected;
  logic [flfr_pkg::BYTE_W-1:0] cmp_a, cmp_b;
  logic          cmp_eq;
  logic          step_ok, done;
  logic          in_acc;

  // Effective length: zero acts as one, oversize clamps to the store depth.
  always_comb begin
    pl_w = WW'(cfg.payload_length);
    if (pl_w == '0) begin
      len_w = WW'(1);
    end else if (pl_w > WW'(PAYLOAD_MAX)) begin
      len_w = WW'(PAYLOAD_MAX);
    end else begin
      len_w = pl_w;
    end
  end

  assign mark_w  = WW'(flfr_pkg::MARK_LEN);
  assign pos_w   = WW'(pos_r);
  assign pos_inc = pos_w + WW'(1);
  assign pay_end = mark_w + len_w;
  assign trl_end = pay_end + mark_w;
  assign in_pre  = pos_w < mark_w;
  assign in_pay  = !in_pre && (pos_w < pay_end);
  assign in_trl  = !in_pre && !in_pay && (pos_w < trl_end);

  assign mark_idx = in_pre ? 3'(pos_w) : 3'(pos_w - pay_end);
  assign expected = flfr_pkg::mark_byte(in_pre ? cfg.preamble_word : cfg.trailer_word,
                                        mark_idx);

  // The one comparator: marker bytes while framing, last-byte test while draining.
  always_comb begin
    if (state_r == flfr_pkg::S_LOAD) begin
      cmp_a = flfr_pkg::BYTE_W'(k_r);
      cmp_b = flfr_pkg::BYTE_W'(len_w - WW'(1));
    end else begin
      cmp_a = byte_r;
      cmp_b = expected;
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign step_ok = in_pay || ((in_pre || in_trl) && cmp_eq);
  assign done    = step_ok && (pos_inc == trl_end);

  assign in_acc = in_if.valid && in_if.ready;

  assign in_if.ready          = (state_r == flfr_pkg::S_IDLE);
  assign out_if.valid         = (state_r == flfr_pkg::S_SEND);
  assign out_if.payload_byte  = out_byte_r;
  assign out_if.payload_index = out_idx_r;
  assign out_if.last          = last_r;

  assign wr_en   = (state_r == flfr_pkg::S_EVAL) && in_pay;
  assign wr_addr = AW'(pos_w - mark_w);
  assign wr_data = byte_r;
  assign rd_en   = (state_r == flfr_pkg::S_READ);
  assign rd_addr = k_r;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    byte_nxt     = byte_r;
    k_nxt        = k_r;
    out_byte_nxt = out_byte_r;
    out_idx_nxt  = out_idx_r;
    last_nxt     = last_r;
    unique case (state_r)
      flfr_pkg::S_IDLE: begin
        // Error bytes are taken and dropped without touching any state.
        if (in_acc && !in_if.rx_error) begin
          byte_nxt  = in_if.rx_byte;
          state_nxt = flfr_pkg::S_EVAL;
        end
      end
      flfr_pkg::S_EVAL: begin
        if (!step_ok || done) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = POS_W'(pos_inc);
        end
        k_nxt     = '0;
        state_nxt = done ? flfr_pkg::S_READ : flfr_pkg::S_IDLE;
      end
      flfr_pkg::S_READ: begin
        state_nxt = flfr_pkg::S_LOAD;
      end
      flfr_pkg::S_LOAD: begin
        out_byte_nxt = rd_data;
        out_idx_nxt  = flfr_pkg::INDEX_W'(k_r);
        last_nxt     = cmp_eq;
        state_nxt    = flfr_pkg::S_SEND;
      end
      flfr_pkg::S_SEND: begin
        if (out_if.ready) begin
          if (last_r) begin
            state_nxt = flfr_pkg::S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = flfr_pkg::S_READ;
          end
        end
      end
      default: state_nxt = flfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flfr_pkg::S_IDLE;
      pos_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    last_r     <= last_nxt;
  end

  // A result is never offered while an input byte can be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !out_if.valid)
    else $error("flfr_ctrl: result offered while accepting input");

  // A dropped error byte leaves the frame position and the sequencer alone.
  a_error_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.rx_error) |=> (state_r == flfr_pkg::S_IDLE) && $stable(pos_r))
    else $error("flfr_ctrl: error byte changed state");

  // After the final payload byte leaves, the block is back at frame start.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last) |=> in_if.ready && (pos_r == '0))
    else $error("flfr_ctrl: not idle at frame start after last byte");

endmodule

[hdl/fixed_length_frame_receiver_top.sv]
// Top level of the fixed-length frame receiver.
`timescale 1ns / 1ps

// Channel   Modport  Payload                                   Handshake
// in_if     sink     rx_byte[7:0], rx_error                    valid / ready
// out_if    source   payload_byte[7:0], payload_index[4:0], last  valid / ready
// cfg_if    sink     index[1:0], wdata[39:0]                   valid / ready (always ready)
//
// A good byte is accepted in S_IDLE and evaluated in S_EVAL, which tests marker bytes in the
// shared comparator, updates the frame position and writes payload bytes to memory.
// A byte flagged with rx_error is accepted and dropped.
// When the trailer completes, the payload drains one byte at a time (memory read, output load,
// offer), each offer held until out_if.ready is high; no input is taken meanwhile.
// Reset (rst_n low, synchronous) clears the sequencer and restores the register defaults;
// the payload memory is not cleared, so there is no start-up pass.

module fixed_length_frame_receiver_top #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  flfr_in_if.sink     in_if,
  flfr_out_if.source  out_if,
  flfr_cfg_if.sink    cfg_if
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  // Live configuration: length and the two marker words.
  flfr_pkg::cfg_regs_t cfg;

  // Payload memory connections between the sequencer and the store.
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [flfr_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [flfr_pkg::BYTE_W-1:0] rd_data;

  // Configuration writes land here; they are expected only while the block is idle.
  flfr_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Payload bytes are written as they arrive and read back one at a time to drain.
  flfr_store #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The sequencer walks preamble, payload and trailer, and then emits the frame.
  flfr_ctrl #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_if   (in_if),
    .out_if  (out_if),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
